// File: rtl/core/spcs_pkg.sv
package spcs_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int TAG_W = 16;
	localparam int LEN_W = 16;
	localparam int CLASS_W = 2;
	localparam int TOTAL_W = 32;
	localparam int ENTRY_W = TAG_W + LEN_W;

	localparam logic OPER_ARRIVAL = 1'b0;
	localparam logic OPER_TICK = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [CLASS_W-1:0] call_class;
		logic [TAG_W-1:0]   call_tag;
		logic [LEN_W-1:0]   call_length;
	} call_req_t;

	typedef struct packed {
		logic               arrival_accepted;
		logic               arrival_dropped;
		logic               started;
		logic [TAG_W-1:0]   started_tag;
		logic [CLASS_W-1:0] started_class;
		logic               finished;
		logic [LEN_W-1:0]   remaining_busy;
		logic [TOTAL_W-1:0] completed_total;
	} call_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FETCH,
		ST_RESPOND
	} ctrl_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LATCH,
		OP_ARRIVE,
		OP_COUNT,
		OP_EMPTY,
		OP_PICK,
		OP_SERVE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic server_busy;
		logic any_pending;
	} dp_status_t;

endpackage

// File: rtl/core/strict_priority_call_scheduler.sv
// Each request passes from acceptance through the decide state to its result strobe, and also
// through the fetch state when an idle server answers a queued call: the queue memory read is
// registered before it is used. A new request is accepted in the cycle the previous result is
// strobed, so the block takes no new request before the last is answered. The result is valid
// for exactly one cycle on done; the receiver cannot stall it. Reset clears the queue pointers,
// fill counts, server countdown and completed total; queue contents are undefined until written.
module strict_priority_call_scheduler #(
	parameter int QUEUE_DEPTH = spcs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  spcs_pkg::call_req_t req,
	output logic                busy,
	output logic                done,
	output spcs_pkg::call_rsp_t rsp
);
	import spcs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	spcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	spcs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

// File: rtl/core/spcs_ctrl.sv
module spcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  spcs_pkg::dp_status_t status,
	output spcs_pkg::dp_cmd_t   cmd,
	output logic                busy,
	output logic                done
);
	import spcs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE, ST_RESPOND: begin
				if (start) begin
					state_nx = ST_DECIDE;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_DECIDE: begin
				if (status.is_tick && !status.server_busy && status.any_pending) begin
					state_nx = ST_FETCH;
				end else begin
					state_nx = ST_RESPOND;
				end
			end
			ST_FETCH: state_nx = ST_RESPOND;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		busy = 1'b0;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op = OP_LATCH;
				end
			end
			ST_RESPOND: begin
				done = 1'b1;
				if (start) begin
					cmd.op = OP_LATCH;
				end
			end
			ST_DECIDE: begin
				busy = 1'b1;
				if (!status.is_tick) begin
					cmd.op = OP_ARRIVE;
				end else if (status.server_busy) begin
					cmd.op = OP_COUNT;
				end else if (!status.any_pending) begin
					cmd.op = OP_EMPTY;
				end else begin
					cmd.op = OP_PICK;
				end
			end
			ST_FETCH: begin
				busy = 1'b1;
				cmd.op = OP_SERVE;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// The fetch state only follows a pick made in the decide state.
	a_fetch_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> $past(state_q) == ST_DECIDE)
		else $error("fetch state entered without a preceding pick");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted request did not make the block busy");

endmodule

// File: rtl/core/spcs_dp.sv
module spcs_dp #(
	parameter int QUEUE_DEPTH = spcs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spcs_pkg::call_req_t  req,
	input  spcs_pkg::dp_cmd_t    cmd,
	output spcs_pkg::dp_status_t status,
	output spcs_pkg::call_rsp_t  rsp
);
	import spcs_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	logic [ENTRY_W-1:0] mem [NUM_CLASSES][QUEUE_DEPTH];

	call_req_t          item_q;
	call_rsp_t          rsp_q;
	logic [IDX_W-1:0]   head_q [NUM_CLASSES];
	logic [FILL_W-1:0]  fill_q [NUM_CLASSES];
	logic [LEN_W-1:0]   busy_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ENTRY_W-1:0] rdata_q;
	logic [CLASS_W-1:0] pick_cls_q;

	logic [CLASS_W-1:0] arr_cls;
	logic               arr_full;
	logic [SUM_W-1:0]   tail_sum;
	logic [IDX_W-1:0]   tail_idx;
	logic [CLASS_W-1:0] pick_cls;
	logic               any_pending;
	logic [IDX_W-1:0]   pick_head;
	logic [IDX_W-1:0]   pick_head_nx;
	logic [LEN_W-1:0]   count_nx;
	logic [LEN_W-1:0]   serve_dur;
	logic [LEN_W-1:0]   serve_nx;
	call_rsp_t          rsp_nx;
	logic               rsp_load;

	assign arr_cls = item_q.call_class;
	assign arr_full = (fill_q[arr_cls] == FULL_FILL);
	assign tail_sum = SUM_W'(head_q[arr_cls]) + SUM_W'(fill_q[arr_cls]);
	assign tail_idx = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
	                                          : IDX_W'(tail_sum);

	// Lowest class number with queued calls wins.
	always_comb begin
		pick_cls = CLASS_W'(NUM_CLASSES - 1);
		any_pending = 1'b0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (fill_q[c] != '0) begin
				pick_cls = CLASS_W'(c);
				any_pending = 1'b1;
			end
		end
	end

	assign pick_head = head_q[pick_cls];
	assign pick_head_nx = (pick_head == LAST_IDX) ? '0 : pick_head + 1'b1;

	assign count_nx = busy_q - 1'b1;
	assign serve_dur = rdata_q[LEN_W-1:0];
	assign serve_nx = (serve_dur == '0) ? '0 : serve_dur - 1'b1;

	assign status.is_tick = (item_q.operation == OPER_TICK);
	assign status.server_busy = (busy_q != '0);
	assign status.any_pending = any_pending;
	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ARRIVE && !arr_full) begin
			mem[arr_cls][tail_idx] <= {item_q.call_tag, item_q.call_length};
		end
		if (cmd.op == OP_PICK) begin
			rdata_q <= mem[pick_cls][pick_head];
			pick_cls_q <= pick_cls;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				fill_q[c] <= '0;
			end
			busy_q <= '0;
			total_q <= '0;
		end else begin
			case (cmd.op)
				OP_ARRIVE: begin
					if (!arr_full) begin
						fill_q[arr_cls] <= fill_q[arr_cls] + 1'b1;
					end
				end
				OP_COUNT: begin
					busy_q <= count_nx;
					if (count_nx == '0) begin
						total_q <= total_q + 1'b1;
					end
				end
				OP_PICK: begin
					head_q[pick_cls] <= pick_head_nx;
					fill_q[pick_cls] <= fill_q[pick_cls] - 1'b1;
				end
				OP_SERVE: begin
					busy_q <= serve_nx;
					if (serve_nx == '0) begin
						total_q <= total_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result contents; counts shown are those after the request is applied.
	always_comb begin
		rsp_nx = '0;
		rsp_load = 1'b1;
		case (cmd.op)
			OP_ARRIVE: begin
				rsp_nx.arrival_accepted = !arr_full;
				rsp_nx.arrival_dropped = arr_full;
				rsp_nx.remaining_busy = busy_q;
				rsp_nx.completed_total = total_q;
			end
			OP_COUNT: begin
				rsp_nx.finished = (count_nx == '0);
				rsp_nx.remaining_busy = count_nx;
				rsp_nx.completed_total = total_q + TOTAL_W'(count_nx == '0);
			end
			OP_EMPTY: begin
				rsp_nx.remaining_busy = busy_q;
				rsp_nx.completed_total = total_q;
			end
			OP_SERVE: begin
				rsp_nx.started = 1'b1;
				rsp_nx.started_tag = rdata_q[ENTRY_W-1:LEN_W];
				rsp_nx.started_class = pick_cls_q;
				rsp_nx.finished = (serve_nx == '0);
				rsp_nx.remaining_busy = serve_nx;
				rsp_nx.completed_total = total_q + TOTAL_W'(serve_nx == '0);
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_nx;
		end
	end

	a_pick_has_call: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_PICK |-> any_pending && busy_q == '0)
		else $error("pick issued with no queued call or a busy server");

	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_COUNT |-> busy_q != '0)
		else $error("countdown issued on an idle server");

	a_drop_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_ARRIVE && arr_full |=> $stable(total_q) && $stable(busy_q)
			&& rsp_q.arrival_dropped)
		else $error("dropped arrival changed server state");

	a_serve_reports: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SERVE |=> rsp_q.started && !rsp_q.arrival_accepted)
		else $error("served call not reported as started");

endmodule

// File: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spcs_pkg::*;

	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam int STALL_LIMIT = 400;
	localparam int MAX_SHOWN = 10;
	localparam int SEGMENTS = 14;
	localparam int SEGMENT_ITEMS = 50;

	logic      clk;
	logic      arst_n;
	logic      start;
	call_req_t req;
	logic      busy;
	logic      done;
	call_rsp_t rsp;

	strict_priority_call_scheduler #(
		.QUEUE_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Shadow copy of the scheduler state.
	logic [ENTRY_W-1:0] line_store [NUM_CLASSES][DEPTH];
	int unsigned        line_head [NUM_CLASSES];
	int unsigned        line_fill [NUM_CLASSES];
	logic [LEN_W-1:0]   server_left;
	logic [TOTAL_W-1:0] calls_done;

	call_rsp_t rsp_pending [$];

	typedef struct {
		call_req_t req;
		int        reps;
		bit        typed;
		call_rsp_t want;
	} plan_row_t;

	plan_row_t plan [$];

	int  bad_results;
	int  results_seen;
	int  stall_cycles;
	bit  quiet;
	int  n_requests, n_queued, n_dropped, n_answered, n_completed, n_idle_empty;
	call_rsp_t want_rsp;

	function automatic call_rsp_t schedule_step(call_req_t r);
		call_rsp_t        o;
		int unsigned      slot;
		logic [ENTRY_W-1:0] entry;
		bit               picked;
		int               c;
		o = '0;
		picked = 1'b0;
		if (r.operation == OPER_ARRIVAL) begin
			if (line_fill[r.call_class] >= DEPTH) begin
				o.arrival_dropped = 1'b1;
			end else begin
				slot = (line_head[r.call_class] + line_fill[r.call_class]) % DEPTH;
				line_store[r.call_class][slot] = {r.call_tag, r.call_length};
				line_fill[r.call_class]++;
				o.arrival_accepted = 1'b1;
			end
		end else if (server_left != '0) begin
			server_left = server_left - 1'b1;
			if (server_left == '0) begin
				calls_done = calls_done + 1'b1;
				o.finished = 1'b1;
			end
		end else begin
			for (c = 0; c < NUM_CLASSES; c++) begin
				if (!picked && line_fill[c] != 0) begin
					entry = line_store[c][line_head[c]];
					line_head[c] = (line_head[c] + 1) % DEPTH;
					line_fill[c]--;
					picked = 1'b1;
					o.started = 1'b1;
					o.started_tag = entry[ENTRY_W-1:LEN_W];
					o.started_class = CLASS_W'(c);
					// Zero and one both finish on the answering tick.
					server_left = (entry[LEN_W-1:0] == '0) ? '0 : entry[LEN_W-1:0] - 1'b1;
					if (server_left == '0) begin
						calls_done = calls_done + 1'b1;
						o.finished = 1'b1;
					end
				end
			end
		end
		o.remaining_busy = server_left;
		o.completed_total = calls_done;
		return o;
	endfunction

	function automatic call_req_t mk_req(logic op, int cls, int tag, int len);
		call_req_t r;
		r.operation = op;
		r.call_class = CLASS_W'(cls);
		r.call_tag = TAG_W'(tag);
		r.call_length = LEN_W'(len);
		return r;
	endfunction

	function automatic call_rsp_t mk_rsp(bit acc, bit drop, bit st, int tag, int cls, bit fin,
			int rem, int total);
		call_rsp_t o;
		o.arrival_accepted = acc;
		o.arrival_dropped = drop;
		o.started = st;
		o.started_tag = TAG_W'(tag);
		o.started_class = CLASS_W'(cls);
		o.finished = fin;
		o.remaining_busy = LEN_W'(rem);
		o.completed_total = TOTAL_W'(total);
		return o;
	endfunction

	function automatic string describe(call_rsp_t o);
		return $sformatf("acc=%0b drop=%0b start=%0b tag=%h cls=%0d fin=%0b rem=%0d total=%0d",
			o.arrival_accepted, o.arrival_dropped, o.started, o.started_tag,
			o.started_class, o.finished, o.remaining_busy, o.completed_total);
	endfunction

	function automatic int pick_gap();
		return quiet ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic add_row(call_req_t r, int reps, bit typed, call_rsp_t w);
		plan_row_t row;
		row.req = r;
		row.reps = reps;
		row.typed = typed;
		row.want = w;
		plan.push_back(row);
	endtask

	// Presents one request, waits for the block to take it, then records what it should return.
	task automatic send_call(call_req_t r, int gap, bit typed, call_rsp_t w);
		call_rsp_t o;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		o = schedule_step(r);
		rsp_pending.push_back(typed ? w : o);
		n_requests++;
		n_queued += o.arrival_accepted;
		n_dropped += o.arrival_dropped;
		n_answered += o.started;
		n_completed += o.finished;
		if (r.operation == OPER_TICK && !o.started && !o.finished && o.remaining_busy == '0)
			n_idle_empty++;
	endtask

	task automatic drain_wait();
		start <= 1'b0;
		do @(posedge clk); while (rsp_pending.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				results_seen++;
				if (rsp_pending.size() == 0) begin
					if (bad_results < MAX_SHOWN)
						$display("unexpected result %0d: %s", results_seen, describe(rsp));
					bad_results++;
				end else begin
					want_rsp = rsp_pending.pop_front();
					if (rsp.arrival_accepted !== want_rsp.arrival_accepted ||
						rsp.arrival_dropped !== want_rsp.arrival_dropped ||
						rsp.started !== want_rsp.started ||
						rsp.started_tag !== want_rsp.started_tag ||
						rsp.started_class !== want_rsp.started_class ||
						rsp.finished !== want_rsp.finished ||
						rsp.remaining_busy !== want_rsp.remaining_busy ||
						rsp.completed_total !== want_rsp.completed_total) begin
						if (bad_results < MAX_SHOWN) begin
							$display("result %0d expected %s", results_seen, describe(want_rsp));
							$display("result %0d got      %s", results_seen, describe(rsp));
						end
						bad_results++;
					end
				end
			end
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("strict_priority_call_scheduler: mismatch");
				$finish;
			end
		end
	end

	initial begin
		call_req_t r;
		call_rsp_t w;
		int        k, seg, pct, sel, len;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		quiet = 1'b0;
		bad_results = 0;
		results_seen = 0;
		stall_cycles = 0;
		n_requests = 0;
		n_queued = 0;
		n_dropped = 0;
		n_answered = 0;
		n_completed = 0;
		n_idle_empty = 0;
		for (k = 0; k < NUM_CLASSES; k++) begin
			line_head[k] = 0;
			line_fill[k] = 0;
			for (sel = 0; sel < DEPTH; sel++)
				line_store[k][sel] = '0;
		end
		server_left = '0;
		calls_done = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick right after reset ignores its payload and finds nothing to do.
		add_row(mk_req(OPER_TICK, 3, 'hFFFF, 'hFFFF), 1, 1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_req(OPER_ARRIVAL, 0, 'hFFFF, 0), 1, 1'b1, mk_rsp(1, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_req(OPER_TICK, 0, 0, 0), 1, 1'b1, mk_rsp(0, 0, 1, 'hFFFF, 0, 1, 0, 1));
		add_row(mk_req(OPER_ARRIVAL, 1, 0, 1), 1, 1'b1, mk_rsp(1, 0, 0, 0, 0, 0, 0, 1));
		add_row(mk_req(OPER_TICK, 2, 'h5555, 'hAAAA), 1, 1'b1, mk_rsp(0, 0, 1, 0, 1, 1, 0, 2));
		// Fill the silver queue to the brim, then one more arrival is turned away.
		add_row(mk_req(OPER_ARRIVAL, 2, 'h5000, 0), DEPTH, 1'b1, mk_rsp(1, 0, 0, 0, 0, 0, 0, 2));
		add_row(mk_req(OPER_ARRIVAL, 2, 'hFFFF, 'hFFFF), 1, 1'b1, mk_rsp(0, 1, 0, 0, 0, 0, 0, 2));
		add_row(mk_req(OPER_ARRIVAL, 3, 'h1234, 3), 1, 1'b0, '0);
		add_row(mk_req(OPER_ARRIVAL, 1, 'h00AA, 1), 1, 1'b0, '0);
		add_row(mk_req(OPER_ARRIVAL, 0, 'h0F0F, 2), 1, 1'b0, '0);
		add_row(mk_req(OPER_TICK, 0, 0, 0), 1, 1'b0, '0);
		// A platinum arrival during service must wait; the server does not preempt.
		add_row(mk_req(OPER_ARRIVAL, 0, 'hF0F0, 1), 1, 1'b0, '0);
		add_row(mk_req(OPER_TICK, 1, 'h8001, 'h7FFE), 3, 1'b0, '0);

		foreach (plan[i]) begin
			for (k = 0; k < plan[i].reps; k++) begin
				r = plan[i].req;
				if (r.operation == OPER_ARRIVAL)
					r.call_tag = r.call_tag + TAG_W'(k);
				send_call(r, pick_gap(), plan[i].typed, plan[i].want);
			end
		end

		drain_wait();

		for (seg = 0; seg < SEGMENTS; seg++) begin
			case ($urandom_range(0, 2))
				0: pct = 15;
				1: pct = 50;
				default: pct = 85;
			endcase
			quiet = ($urandom_range(0, 3) == 0);
			if (seg == SEGMENTS / 2)
				drain_wait();
			for (k = 0; k < SEGMENT_ITEMS; k++) begin
				r.call_class = CLASS_W'($urandom_range(0, 3));
				r.call_tag = TAG_W'($urandom);
				if ($urandom_range(1, 100) <= pct) begin
					r.operation = OPER_ARRIVAL;
					// Mostly short calls so the queues keep moving.
					sel = $urandom_range(0, 19);
					if (sel < 14)
						len = $urandom_range(0, 3);
					else if (sel < 19)
						len = $urandom_range(4, 15);
					else
						len = $urandom_range(16, 60);
					r.call_length = LEN_W'(len);
				end else begin
					r.operation = OPER_TICK;
					r.call_length = LEN_W'($urandom);
				end
				w = '0;
				send_call(r, pick_gap(), 1'b0, w);
			end
		end

		start <= 1'b0;
		while (rsp_pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d requests: %0d queued, %0d turned away at a full queue",
			n_requests, n_queued, n_dropped);
		$display("%0d calls answered, %0d completed, %0d idle ticks with empty queues, %0d bad",
			n_answered, n_completed, n_idle_empty, bad_results);
		if (bad_results == 0 && rsp_pending.size() == 0) begin
			$display("strict_priority_call_scheduler: match");
		end else begin
			$display("strict_priority_call_scheduler: mismatch");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/spcs_pkg.sv
rtl/core/spcs_ctrl.sv
rtl/core/spcs_dp.sv
rtl/core/strict_priority_call_scheduler.sv
bench/tb.sv
